[hdl/cnmf_pkg.sv]
// Package for the calendar next-match finder: shared types, constants and
// calendar arithmetic. No dependencies.
package cnmf_pkg;

  localparam int unsigned SEARCH_YEARS = 2;
  localparam logic [11:0] YEAR_LIMIT  = 12'd4095;
  localparam logic [16:0] TOD_LAST    = 17'd86399;

  typedef enum logic [2:0] {
    REG_MONTH    = 3'd0,
    REG_WEEKDAY  = 3'd1,
    REG_MONTHDAY = 3'd2,
    REG_HOUR     = 3'd3,
    REG_MINUTE   = 3'd4,
    REG_SECOND   = 3'd5,
    REG_START    = 3'd6,
    REG_END      = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    SRC_NOW   = 3'd0,
    SRC_LAST  = 3'd1,
    SRC_START = 3'd2,
    SRC_END   = 3'd3,
    SRC_CUR   = 3'd4
  } src_e;

  typedef struct packed {
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
    logic [30:0] monthday_mask;
    logic [23:0] hour_mask;
    logic [59:0] minute_mask;
    logic [59:0] second_mask;
    logic [37:0] start_bound;
    logic [37:0] end_bound;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic dn_en;
    logic inst_en;
    src_e src;
    logic origin;
    logic mon_chk;
    logic day_chk;
    logic day_next;
    logic lo_en;
    logic div1;
    logic div2;
    logic tm_en;
    logic post;
    logic hit;
  } cmd_t;

  typedef struct packed {
    logic year_over;
    logic mon_skip;
    logic day_over;
    logic day_skip;
    logic wk_off;
    logic lo_over;
    logic tm_none;
    logic end_fail;
  } sts_t;

  function automatic logic leap_year(input logic [11:0] y);
    logic [24:0] p100;
    logic [22:0] p400;
    logic [11:0] r100;
    logic [11:0] r400;
    p100 = 25'(y) * 25'd5243;
    p400 = 23'(y[11:2]) * 23'd5243;
    r100 = y - 12'(12'(p100[24:19]) * 12'd100);
    r400 = y - 12'(12'(p400[22:19]) * 12'd400);
    return ((y[1:0] == 2'd0) && (r100 != 12'd0)) || (r400 == 12'd0);
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2:                    r = leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // Day count from 0000-01-01; month clamped to 1..12, day may be zero.
  function automatic logic signed [21:0] day_number(input logic [11:0] y,
                                                    input logic [3:0] m,
                                                    input logic [4:0] d);
    logic [3:0]  mc;
    logic [12:0] a99;
    logic [12:0] a399;
    logic [25:0] p99;
    logic [23:0] p399;
    logic [21:0] n;
    mc   = (m < 4'd1) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
    a99  = 13'(y) + 13'd99;
    a399 = 13'(y) + 13'd399;
    p99  = 26'(a99) * 26'd5243;
    p399 = 24'(a399[12:2]) * 24'd5243;
    n = 22'(y) * 22'd365;
    if (y != 12'd0) begin
      n = n + 22'((13'(y) + 13'd3) >> 2) - 22'(p99[25:19]) + 22'(p399[23:19]);
    end
    n = n + 22'(month_start(mc));
    if (mc > 4'd2 && leap_year(y)) begin
      n = n + 22'd1;
    end
    n = n + 22'(d) - 22'd1;
    return $signed(n);
  endfunction

  function automatic logic [16:0] tod(input logic [4:0] h, input logic [5:0] mi,
                                      input logic [5:0] s);
    return 17'(h) * 17'd3600 + 17'(mi) * 17'd60 + 17'(s);
  endfunction

  // Residue mod 7 by octal digit folding (8 = 1 mod 7).
  function automatic logic [2:0] mod7(input logic [21:0] v);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    w  = {2'b0, v};
    s1 = 6'd0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd14) s2 = s2 - 4'd14;
    else if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

  // {found, position} of the lowest set bit at or above from.
  function automatic logic [6:0] first_from(input logic [63:0] mask, input logic [6:0] from);
    logic       f;
    logic [5:0] p;
    f = 1'b0;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (!f && (7'(i) >= from) && mask[i]) begin
        f = 1'b1;
        p = 6'(i);
      end
    end
    return {f, p};
  endfunction

endpackage

[hdl/cnmf_regs.sv]
// Configuration register file on an APB-style port.
// Depends on cnmf_pkg.
module cnmf_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cnmf_pkg::cfg_t    cfg_o
);

  cnmf_pkg::cfg_t   cfg_q;
  cnmf_pkg::reg_e   idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = cnmf_pkg::reg_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.month_mask    <= '1;
      cfg_q.weekday_mask  <= '1;
      cfg_q.monthday_mask <= '1;
      cfg_q.hour_mask     <= '1;
      cfg_q.minute_mask   <= '1;
      cfg_q.second_mask   <= '1;
      cfg_q.start_bound   <= '0;
      cfg_q.end_bound     <= '0;
    end else if (wr) begin
      unique case (idx)
        cnmf_pkg::REG_MONTH:    cfg_q.month_mask    <= pwdata[11:0];
        cnmf_pkg::REG_WEEKDAY:  cfg_q.weekday_mask  <= pwdata[6:0];
        cnmf_pkg::REG_MONTHDAY: cfg_q.monthday_mask <= pwdata[30:0];
        cnmf_pkg::REG_HOUR:     cfg_q.hour_mask     <= pwdata[23:0];
        cnmf_pkg::REG_MINUTE:   cfg_q.minute_mask   <= pwdata[59:0];
        cnmf_pkg::REG_SECOND:   cfg_q.second_mask   <= pwdata[59:0];
        cnmf_pkg::REG_START:    cfg_q.start_bound   <= pwdata[37:0];
        cnmf_pkg::REG_END:      cfg_q.end_bound     <= pwdata[37:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cnmf_pkg::REG_MONTH:    prdata = 64'(cfg_q.month_mask);
      cnmf_pkg::REG_WEEKDAY:  prdata = 64'(cfg_q.weekday_mask);
      cnmf_pkg::REG_MONTHDAY: prdata = 64'(cfg_q.monthday_mask);
      cnmf_pkg::REG_HOUR:     prdata = 64'(cfg_q.hour_mask);
      cnmf_pkg::REG_MINUTE:   prdata = 64'(cfg_q.minute_mask);
      cnmf_pkg::REG_SECOND:   prdata = 64'(cfg_q.second_mask);
      cnmf_pkg::REG_START:    prdata = 64'(cfg_q.start_bound);
      cnmf_pkg::REG_END:      prdata = 64'(cfg_q.end_bound);
    endcase
  end

endmodule

[hdl/cnmf_dp.sv]
// Datapath: instant arithmetic, calendar cursor, time-of-day search, result registers.
// Depends on cnmf_pkg; driven by cnmf_ctrl commands.
module cnmf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnmf_pkg::cmd_t     cmd_i,
  output cnmf_pkg::sts_t     sts_o,
  input  cnmf_pkg::cfg_t     cfg_i,
  input  logic [11:0]        now_year_i,
  input  logic [3:0]         now_month_i,
  input  logic [4:0]         now_day_i,
  input  logic [4:0]         now_hour_i,
  input  logic [5:0]         now_minute_i,
  input  logic [5:0]         now_second_i,
  input  logic               last_valid_i,
  input  logic [37:0]        last_stamp_i,
  output logic               done_o,
  output logic               found_o,
  output logic [11:0]        next_year_o,
  output logic [3:0]         next_month_o,
  output logic [4:0]         next_day_o,
  output logic [4:0]         next_hour_o,
  output logic [5:0]         next_minute_o,
  output logic [5:0]         next_second_o
);

  // latched query
  logic [11:0] ny_q;
  logic [3:0]  nm_q;
  logic [4:0]  nd_q, nh_q;
  logic [5:0]  nmi_q, ns_q;
  logic        lv_q;
  logic [37:0] ls_q;

  logic signed [21:0] dn_q;
  logic signed [39:0] nowi_q, lasti_q, sti_q, endi_q, dayi_q;

  // cursor
  logic [12:0] y_q;
  logic [3:0]  m_q;
  logic [5:0]  d_q;
  logic        first_q;
  logic [11:0] ymax_q;
  logic [16:0] base_q;
  logic [4:0]  dim_q;

  // time search
  logic [16:0] lo_q;
  logic [10:0] q_q;
  logic [5:0]  s0_q, m0_q;
  logic [4:0]  h0_q;
  logic [4:0]  th_q;
  logic [5:0]  tm_q, ts_q;

  logic        done_q, found_q;
  logic [11:0] oy_q;
  logic [3:0]  om_q;
  logic [4:0]  od_q, oh_q;
  logic [5:0]  omi_q, os_q;

  // source select for day number / instant
  logic [11:0] sy;
  logic [3:0]  sm;
  logic [4:0]  sd;
  logic [16:0] stod;
  logic [37:0] pk;

  always_comb begin
    pk   = ls_q;
    sy   = ny_q;
    sm   = nm_q;
    sd   = nd_q;
    stod = cnmf_pkg::tod(nh_q, nmi_q, ns_q);
    unique case (cmd_i.src)
      cnmf_pkg::SRC_NOW: begin
      end
      cnmf_pkg::SRC_LAST,
      cnmf_pkg::SRC_START,
      cnmf_pkg::SRC_END: begin
        if (cmd_i.src == cnmf_pkg::SRC_START) pk = cfg_i.start_bound;
        else if (cmd_i.src == cnmf_pkg::SRC_END) pk = cfg_i.end_bound;
        sy   = pk[37:26];
        sm   = pk[25:22];
        sd   = pk[21:17];
        stod = cnmf_pkg::tod(pk[16:12], pk[11:6], pk[5:0]);
      end
      cnmf_pkg::SRC_CUR: begin
        sy   = y_q[11:0];
        sm   = m_q;
        sd   = d_q[4:0];
        stod = 17'd0;
      end
      default: begin
      end
    endcase
  end

  logic signed [39:0] inst_val;
  assign inst_val = {{18{dn_q[21]}}, dn_q} * 40'sd86400 + $signed({23'b0, stod});

  // origin selection
  logic        use_st;
  logic [11:0] oy;
  logic [3:0]  om;
  logic [4:0]  od;
  logic [16:0] otod;
  logic [12:0] ysum;

  assign use_st = (cfg_i.start_bound != '0) && (sti_q > nowi_q);
  assign oy   = use_st ? cfg_i.start_bound[37:26] : ny_q;
  assign om   = use_st ? cfg_i.start_bound[25:22] : nm_q;
  assign od   = use_st ? cfg_i.start_bound[21:17] : nd_q;
  assign otod = use_st ? cnmf_pkg::tod(cfg_i.start_bound[16:12], cfg_i.start_bound[11:6],
                                       cfg_i.start_bound[5:0])
                       : cnmf_pkg::tod(nh_q, nmi_q, ns_q);
  assign ysum = 13'(oy) + 13'(cnmf_pkg::SEARCH_YEARS);

  // scan status
  logic [3:0] mi_idx;
  logic [4:0] di_idx;
  logic [2:0] wd;
  assign mi_idx = m_q - 4'd1;
  assign di_idx = d_q[4:0] - 5'd1;
  assign wd     = cnmf_pkg::mod7(22'(dn_q) + 22'd5);

  logic signed [40:0] diff, base_eff, lo_val;
  assign diff     = {lasti_q[39], lasti_q} + 41'sd2 - {dayi_q[39], dayi_q};
  assign base_eff = first_q ? $signed({24'b0, base_q}) : 41'sd0;
  assign lo_val   = (lv_q && diff > base_eff) ? diff : base_eff;

  // divide lo by 60 and 3600 through reciprocals
  logic [34:0] p1;
  logic [21:0] p2;
  logic [10:0] q1;
  logic [4:0]  h1;
  assign p1 = 35'(lo_q) * 35'd139811;
  assign q1 = p1[33:23];
  assign p2 = 22'(q_q) * 22'd1093;
  assign h1 = p2[20:16];

  // time-of-day search
  logic [6:0] sec_all, sec_from, min_after, min_all, hour_after;
  logic       hbit, mbit, c1, c2, c3;
  assign sec_all    = cnmf_pkg::first_from({4'b0, cfg_i.second_mask}, 7'd0);
  assign sec_from   = cnmf_pkg::first_from({4'b0, cfg_i.second_mask}, 7'(s0_q));
  assign min_after  = cnmf_pkg::first_from({4'b0, cfg_i.minute_mask}, 7'(m0_q) + 7'd1);
  assign min_all    = cnmf_pkg::first_from({4'b0, cfg_i.minute_mask}, 7'd0);
  assign hour_after = cnmf_pkg::first_from({40'b0, cfg_i.hour_mask}, 7'(h0_q) + 7'd1);
  assign hbit = cfg_i.hour_mask[h0_q];
  assign mbit = cfg_i.minute_mask[m0_q];
  assign c1 = hbit && mbit && sec_from[6];
  assign c2 = hbit && sec_all[6] && min_after[6];
  assign c3 = sec_all[6] && hour_after[6] && min_all[6];

  logic signed [39:0] cand;
  assign cand = dayi_q + $signed({23'b0, cnmf_pkg::tod(th_q, tm_q, ts_q)});

  always_comb begin
    sts_o.year_over = y_q > 13'(ymax_q);
    sts_o.mon_skip  = (m_q > 4'd12) || !cfg_i.month_mask[mi_idx];
    sts_o.day_over  = d_q > 6'(dim_q);
    sts_o.day_skip  = !cfg_i.monthday_mask[di_idx];
    sts_o.wk_off    = !cfg_i.weekday_mask[wd];
    sts_o.lo_over   = lo_val > $signed({24'b0, cnmf_pkg::TOD_LAST});
    sts_o.tm_none   = !(c1 || c2 || c3);
    sts_o.end_fail  = (cfg_i.end_bound != '0) && (endi_q < cand);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ny_q  <= now_year_i;
      nm_q  <= now_month_i;
      nd_q  <= now_day_i;
      nh_q  <= now_hour_i;
      nmi_q <= now_minute_i;
      ns_q  <= now_second_i;
      lv_q  <= last_valid_i;
      ls_q  <= last_stamp_i;
    end
    if (cmd_i.dn_en) begin
      dn_q <= cnmf_pkg::day_number(sy, sm, sd);
    end
    if (cmd_i.inst_en) begin
      unique case (cmd_i.src)
        cnmf_pkg::SRC_NOW:   nowi_q  <= inst_val;
        cnmf_pkg::SRC_LAST:  lasti_q <= inst_val;
        cnmf_pkg::SRC_START: sti_q   <= inst_val;
        cnmf_pkg::SRC_END:   endi_q  <= inst_val;
        cnmf_pkg::SRC_CUR:   dayi_q  <= inst_val;
        default: begin
        end
      endcase
    end
    if (cmd_i.origin) begin
      ymax_q <= (ysum > 13'(cnmf_pkg::YEAR_LIMIT)) ? cnmf_pkg::YEAR_LIMIT : ysum[11:0];
      if (om == 4'd0) begin
        y_q <= 13'(oy); m_q <= 4'd1; d_q <= 6'd1; base_q <= '0; first_q <= 1'b1;
      end else if (om > 4'd12) begin
        y_q <= 13'(oy) + 13'd1; m_q <= 4'd1; d_q <= 6'd1; base_q <= '0; first_q <= 1'b0;
      end else if (od == 5'd0) begin
        y_q <= 13'(oy); m_q <= om; d_q <= 6'd1; base_q <= '0; first_q <= 1'b1;
      end else begin
        y_q <= 13'(oy); m_q <= om; d_q <= 6'(od); base_q <= otod; first_q <= 1'b1;
      end
    end
    if (cmd_i.mon_chk && !sts_o.year_over) begin
      if (m_q > 4'd12) begin
        y_q <= y_q + 13'd1; m_q <= 4'd1; d_q <= 6'd1; first_q <= 1'b0;
      end else if (!cfg_i.month_mask[mi_idx]) begin
        m_q <= m_q + 4'd1; d_q <= 6'd1; first_q <= 1'b0;
      end else begin
        dim_q <= cnmf_pkg::month_len(y_q[11:0], m_q);
      end
    end
    if (cmd_i.day_chk) begin
      if (sts_o.day_over) begin
        m_q <= m_q + 4'd1; d_q <= 6'd1; first_q <= 1'b0;
      end else if (sts_o.day_skip) begin
        d_q <= d_q + 6'd1; first_q <= 1'b0;
      end
    end
    if (cmd_i.day_next) begin
      d_q <= d_q + 6'd1; first_q <= 1'b0;
    end
    if (cmd_i.lo_en) begin
      lo_q <= lo_val[16:0];
    end
    if (cmd_i.div1) begin
      q_q  <= q1;
      s0_q <= 6'(lo_q - 17'(q1) * 17'd60);
    end
    if (cmd_i.div2) begin
      h0_q <= h1;
      m0_q <= 6'(q_q - 11'(h1) * 11'd60);
    end
    if (cmd_i.tm_en) begin
      if (c1) begin
        th_q <= h0_q; tm_q <= m0_q; ts_q <= sec_from[5:0];
      end else if (c2) begin
        th_q <= h0_q; tm_q <= min_after[5:0]; ts_q <= sec_all[5:0];
      end else begin
        th_q <= hour_after[4:0]; tm_q <= min_all[5:0]; ts_q <= sec_all[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      found_q <= 1'b0;
      oy_q <= '0; om_q <= '0; od_q <= '0; oh_q <= '0; omi_q <= '0; os_q <= '0;
    end else begin
      done_q <= cmd_i.post;
      if (cmd_i.post) begin
        found_q <= cmd_i.hit;
        oy_q  <= cmd_i.hit ? y_q[11:0] : '0;
        om_q  <= cmd_i.hit ? m_q : '0;
        od_q  <= cmd_i.hit ? d_q[4:0] : '0;
        oh_q  <= cmd_i.hit ? th_q : '0;
        omi_q <= cmd_i.hit ? tm_q : '0;
        os_q  <= cmd_i.hit ? ts_q : '0;
      end
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign next_year_o   = oy_q;
  assign next_month_o  = om_q;
  assign next_day_o    = od_q;
  assign next_hour_o   = oh_q;
  assign next_minute_o = omi_q;
  assign next_second_o = os_q;

endmodule

[hdl/cnmf_ctrl.sv]
// Controller: sequences instant setup, the day scan and the time search.
// Depends on cnmf_pkg; drives cnmf_dp.
module cnmf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output cnmf_pkg::cmd_t     cmd_o,
  input  cnmf_pkg::sts_t     sts_i
);

  typedef enum logic [18:0] {
    ST_IDLE    = 19'h00001,
    ST_DN_NOW  = 19'h00002,
    ST_IN_NOW  = 19'h00004,
    ST_DN_LAST = 19'h00008,
    ST_IN_LAST = 19'h00010,
    ST_DN_ST   = 19'h00020,
    ST_IN_ST   = 19'h00040,
    ST_DN_END  = 19'h00080,
    ST_IN_END  = 19'h00100,
    ST_ORIGIN  = 19'h00200,
    ST_MONTH   = 19'h00400,
    ST_DAY     = 19'h00800,
    ST_DN_CUR  = 19'h01000,
    ST_WK      = 19'h02000,
    ST_LO      = 19'h04000,
    ST_DIV1    = 19'h08000,
    ST_DIV2    = 19'h10000,
    ST_TIME    = 19'h20000,
    ST_FIN     = 19'h40000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src = cnmf_pkg::SRC_NOW;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
        if (start_i) state_d = ST_DN_NOW;
      end
      ST_DN_NOW: begin
        cmd_o.dn_en = 1'b1; state_d = ST_IN_NOW;
      end
      ST_IN_NOW: begin
        cmd_o.inst_en = 1'b1; state_d = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        cmd_o.src = cnmf_pkg::SRC_LAST; cmd_o.dn_en = 1'b1; state_d = ST_IN_LAST;
      end
      ST_IN_LAST: begin
        cmd_o.src = cnmf_pkg::SRC_LAST; cmd_o.inst_en = 1'b1; state_d = ST_DN_ST;
      end
      ST_DN_ST: begin
        cmd_o.src = cnmf_pkg::SRC_START; cmd_o.dn_en = 1'b1; state_d = ST_IN_ST;
      end
      ST_IN_ST: begin
        cmd_o.src = cnmf_pkg::SRC_START; cmd_o.inst_en = 1'b1; state_d = ST_DN_END;
      end
      ST_DN_END: begin
        cmd_o.src = cnmf_pkg::SRC_END; cmd_o.dn_en = 1'b1; state_d = ST_IN_END;
      end
      ST_IN_END: begin
        cmd_o.src = cnmf_pkg::SRC_END; cmd_o.inst_en = 1'b1; state_d = ST_ORIGIN;
      end
      ST_ORIGIN: begin
        cmd_o.origin = 1'b1; state_d = ST_MONTH;
      end
      ST_MONTH: begin
        cmd_o.mon_chk = 1'b1;
        if (sts_i.year_over) begin
          cmd_o.post = 1'b1; state_d = ST_IDLE;
        end else if (!sts_i.mon_skip) begin
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        cmd_o.day_chk = 1'b1;
        if (sts_i.day_over) state_d = ST_MONTH;
        else if (!sts_i.day_skip) state_d = ST_DN_CUR;
      end
      ST_DN_CUR: begin
        cmd_o.src = cnmf_pkg::SRC_CUR; cmd_o.dn_en = 1'b1; state_d = ST_WK;
      end
      ST_WK: begin
        cmd_o.src = cnmf_pkg::SRC_CUR; cmd_o.inst_en = 1'b1;
        if (sts_i.wk_off) begin
          cmd_o.day_next = 1'b1; state_d = ST_DAY;
        end else begin
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        if (sts_i.lo_over) begin
          cmd_o.day_next = 1'b1; state_d = ST_DAY;
        end else begin
          cmd_o.lo_en = 1'b1; state_d = ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd_o.div1 = 1'b1; state_d = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div2 = 1'b1; state_d = ST_TIME;
      end
      ST_TIME: begin
        if (sts_i.tm_none) begin
          cmd_o.day_next = 1'b1; state_d = ST_DAY;
        end else begin
          cmd_o.tm_en = 1'b1; state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.post = 1'b1;
        cmd_o.hit  = !sts_i.end_fail;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/calendar_next_match_finder.sv]
// Top level of the calendar next-match finder: register file, controller, datapath.
// Depends on cnmf_pkg, cnmf_regs, cnmf_ctrl, cnmf_dp.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------
//  query    | start & !busy                | now_*_i, last_valid_i, last_stamp_i
//  result   | done_o (one cycle)           | found_o, next_*_o
//  config   | psel & penable & pwrite      | paddr (reg at 8*i), pwdata, prdata
//
// A query runs the setup states after the accepting edge, then checks each month (a skipped
// month is passed over, a scanned month goes on to its days) and visits calendar days (a day
// masked out is passed over, as is a day with no fitting time of day), over at most three
// years of days, plus the end-bound check on a hit. done_o is registered from the last state
// and rises in the cycle after it, when busy is already low. Reset sets all masks to all-ones
// and both bounds to zero. The result cannot be stalled.
module calendar_next_match_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] now_year_i,
  input  logic [3:0]  now_month_i,
  input  logic [4:0]  now_day_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,
  input  logic [5:0]  now_second_i,
  input  logic        last_valid_i,
  input  logic [37:0] last_stamp_i,
  output logic        done_o,
  output logic        found_o,
  output logic [11:0] next_year_o,
  output logic [3:0]  next_month_o,
  output logic [4:0]  next_day_o,
  output logic [4:0]  next_hour_o,
  output logic [5:0]  next_minute_o,
  output logic [5:0]  next_second_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cnmf_pkg::cfg_t cfg;
  cnmf_pkg::cmd_t cmd;
  cnmf_pkg::sts_t sts;

  cnmf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cnmf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  cnmf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .now_year_i    (now_year_i),
    .now_month_i   (now_month_i),
    .now_day_i     (now_day_i),
    .now_hour_i    (now_hour_i),
    .now_minute_i  (now_minute_i),
    .now_second_i  (now_second_i),
    .last_valid_i  (last_valid_i),
    .last_stamp_i  (last_stamp_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .next_year_o   (next_year_o),
    .next_month_o  (next_month_o),
    .next_day_o    (next_day_o),
    .next_hour_o   (next_hour_o),
    .next_minute_o (next_minute_o),
    .next_second_o (next_second_o)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a query in flight");
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("still busy after result");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (next_year_o == 12'd0 && next_month_o == 4'd0
                              && next_second_o == 6'd0))
    else $error("not-found result carries data");
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (next_month_o >= 4'd1 && next_month_o <= 4'd12
                             && next_day_o >= 5'd1 && next_hour_o <= 5'd23
                             && next_minute_o <= 6'd59 && next_second_o <= 6'd59))
    else $error("found result out of calendar range");
`endif

endmodule
